>>> sv/stra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stra_pkg: shared types and constants of the range argmax block
// Sizes of the element store and the sparse table, operation and status
// codes, the payload structs and the controller/datapath signal groups.
// ----------------------------------------------------------------------------
package stra_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int LEVELS       = 11;
    localparam int VALUE_WIDTH  = 32;

    localparam int IDX_W   = $clog2(MAX_ELEMENTS);
    localparam int CNT_W   = IDX_W + 1;
    localparam int LVL_W   = $clog2(LEVELS);
    localparam int ADDR_W  = LVL_W + IDX_W;
    localparam int TBL_DEPTH = LEVELS * MAX_ELEMENTS;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_BUILD  = 2'd2,
        OP_QUERY  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_RANGE = 2'd1,
        ST_NOT_BUILT = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        op_t                operation;
        logic signed [31:0] value;
        logic [9:0]         left_index;
        logic [9:0]         right_index;
    } cmd_t;

    typedef struct packed {
        status_t    status;
        logic [9:0] max_position;
    } rsp_t;

    // One table entry: window maximum and where it sits.
    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] val;
        logic [IDX_W-1:0]              pos;
    } entry_t;

    typedef struct packed {
        logic latch;
        logic clear;
        logic append;
        logic set_ready;
        logic query_rd;
        logic query_out;
        logic build_start;
        logic build_rd;
        logic build_next;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        op_t  op;
        logic query_go;
        logic build_empty;
        logic row_more;
        logic lvl_more;
    } dp_stat_t;

    // Level k, entry i of the table lives at k * MAX_ELEMENTS + i.
    function automatic logic [ADDR_W-1:0] tbl_addr(input logic [LVL_W-1:0] lvl,
                                                    input logic [IDX_W-1:0] idx);
        return {lvl, idx};
    endfunction

endpackage

>>> sv/stra_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stra_ctrl: sequencer of the range argmax block
// Takes a command, steps the datapath through decode, query compare or the
// level-by-level table build, and strobes the result.
// ----------------------------------------------------------------------------
module stra_ctrl
    import stra_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  dp_stat_t  stat,
    output ctrl_cmd_t ctl,
    output logic      busy,
    output logic      done
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECODE = 4'b0010,
        S_QCMP   = 4'b0100,
        S_BUILD  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.op)
                    OP_CLEAR:
                    begin
                        ctl.clear  = 1'b1;
                        ctl.emit   = 1'b1;
                        state_next = S_IDLE;
                    end
                    OP_APPEND:
                    begin
                        ctl.append = 1'b1;
                        ctl.emit   = 1'b1;
                        state_next = S_IDLE;
                    end
                    OP_BUILD:
                    begin
                        if (stat.build_empty)
                        begin
                            ctl.set_ready = 1'b1;
                            ctl.emit      = 1'b1;
                            state_next    = S_IDLE;
                        end
                        else
                        begin
                            ctl.build_start = 1'b1;
                            state_next      = S_BUILD;
                        end
                    end
                    OP_QUERY:
                    begin
                        if (stat.query_go)
                        begin
                            ctl.query_rd = 1'b1;
                            state_next   = S_QCMP;
                        end
                        else
                        begin
                            ctl.emit   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_QCMP:
            begin
                ctl.query_out = 1'b1;
                state_next    = S_IDLE;
            end
            S_BUILD:
            begin
                // The cycle with no row left lets the last write of the level land.
                if (stat.row_more)
                begin
                    ctl.build_rd = 1'b1;
                end
                else if (stat.lvl_more)
                begin
                    ctl.build_next = 1'b1;
                end
                else
                begin
                    ctl.set_ready = 1'b1;
                    ctl.emit      = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= ctl.emit | ctl.query_out;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

>>> sv/stra_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stra_dp: datapath of the range argmax block
// Holds the sparse table memory (level 0 is the element store), the element
// count, the build row/level counters, query decode and the result register.
// ----------------------------------------------------------------------------
module stra_dp
    import stra_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      cmd,
    input  ctrl_cmd_t ctl,
    output dp_stat_t  stat,
    output rsp_t      rsp
);

    entry_t mem [TBL_DEPTH];

    cmd_t             cmd_reg;
    rsp_t             rsp_reg, rsp_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ready_reg, ready_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;
    logic [IDX_W-1:0] row_reg, row_next;
    logic             wr_valid_reg, wr_valid_next;
    logic [ADDR_W-1:0] wr_addr_reg, wr_addr_next;
    entry_t           rd_a_reg, rd_b_reg;

    logic [ADDR_W-1:0] rd_a_addr, rd_b_addr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    entry_t            mem_wdata;
    entry_t            win;

    logic              full;
    logic [IDX_W-1:0]  q_l, q_r, q_j;
    logic [CNT_W-1:0]  q_len, q_pow;
    logic [LVL_W-1:0]  q_lvl;
    logic              q_range_bad, q_lvl_bad;
    status_t           dec_status;
    logic [IDX_W-1:0]  b_half;
    logic [CNT_W:0]    b_row_end, b_next_width;

    // Query decode
    assign q_l         = cmd_reg.left_index;
    assign q_r         = cmd_reg.right_index;
    assign q_range_bad = (q_l > q_r) || ({1'b0, q_r} >= count_reg);
    assign q_len       = CNT_W'(q_r) - CNT_W'(q_l) + CNT_W'(1);

    always_comb
    begin
        q_lvl = '0;
        for (int b = 0; b < CNT_W; b++)
        begin
            if (q_len[b])
            begin
                q_lvl = LVL_W'(b);
            end
        end
    end

    assign q_lvl_bad = ({1'b0, q_lvl} >= (LVL_W+1)'(LEVELS));
    assign q_pow     = CNT_W'(1) << q_lvl;
    assign q_j       = IDX_W'(CNT_W'(q_r) + CNT_W'(1) - q_pow);

    assign full = (count_reg >= CNT_W'(MAX_ELEMENTS));

    always_comb
    begin
        dec_status = ST_OK;
        case (cmd_reg.operation)
            OP_APPEND:
            begin
                if (full)
                begin
                    dec_status = ST_FULL;
                end
            end
            OP_QUERY:
            begin
                if (!ready_reg)
                begin
                    dec_status = ST_NOT_BUILT;
                end
                else if (q_range_bad || q_lvl_bad)
                begin
                    dec_status = ST_BAD_RANGE;
                end
            end
            default:
            begin
                dec_status = ST_OK;
            end
        endcase
    end

    // Build addressing: level lvl entry row combines two halves of level lvl-1
    assign b_half       = IDX_W'(1) << (lvl_reg - LVL_W'(1));
    assign b_row_end    = (CNT_W+1)'(row_reg) + ((CNT_W+1)'(1) << lvl_reg);
    assign b_next_width = (CNT_W+1)'(2) << lvl_reg;

    assign stat.op          = cmd_reg.operation;
    assign stat.query_go    = ready_reg && !q_range_bad && !q_lvl_bad;
    assign stat.build_empty = (count_reg < CNT_W'(2));
    assign stat.row_more    = (b_row_end <= (CNT_W+1)'(count_reg));
    assign stat.lvl_more    = ({1'b0, lvl_reg} + (LVL_W+1)'(1) < (LVL_W+1)'(LEVELS))
                              && (b_next_width <= (CNT_W+1)'(count_reg));

    always_comb
    begin
        if (ctl.query_rd)
        begin
            rd_a_addr = tbl_addr(q_lvl, q_l);
            rd_b_addr = tbl_addr(q_lvl, q_j);
        end
        else
        begin
            rd_a_addr = tbl_addr(lvl_reg - LVL_W'(1), row_reg);
            rd_b_addr = tbl_addr(lvl_reg - LVL_W'(1), row_reg + b_half);
        end
    end

    // Left side wins on equal values
    assign win = (rd_a_reg.val >= rd_b_reg.val) ? rd_a_reg : rd_b_reg;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = wr_addr_reg;
        mem_wdata = win;
        if (wr_valid_reg)
        begin
            mem_we = 1'b1;
        end
        else if (ctl.append && !full)
        begin
            mem_we        = 1'b1;
            mem_waddr     = tbl_addr('0, count_reg[IDX_W-1:0]);
            mem_wdata.val = VALUE_WIDTH'(cmd_reg.value);
            mem_wdata.pos = count_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_a_reg <= mem[rd_a_addr];
        rd_b_reg <= mem[rd_b_addr];
    end

    always_comb
    begin
        count_next    = count_reg;
        ready_next    = ready_reg;
        lvl_next      = lvl_reg;
        row_next      = row_reg;
        wr_valid_next = 1'b0;
        wr_addr_next  = wr_addr_reg;
        rsp_next      = rsp_reg;
        if (ctl.clear)
        begin
            count_next = '0;
            ready_next = 1'b0;
        end
        if (ctl.append && !full)
        begin
            count_next = count_reg + CNT_W'(1);
            ready_next = 1'b0;
        end
        if (ctl.set_ready)
        begin
            ready_next = 1'b1;
        end
        if (ctl.build_start)
        begin
            lvl_next = LVL_W'(1);
            row_next = '0;
        end
        if (ctl.build_rd)
        begin
            wr_valid_next = 1'b1;
            wr_addr_next  = tbl_addr(lvl_reg, row_reg);
            row_next      = row_reg + IDX_W'(1);
        end
        if (ctl.build_next)
        begin
            lvl_next = lvl_reg + LVL_W'(1);
            row_next = '0;
        end
        if (ctl.emit)
        begin
            rsp_next.status       = dec_status;
            rsp_next.max_position = '0;
        end
        if (ctl.query_out)
        begin
            rsp_next.status       = ST_OK;
            rsp_next.max_position = 10'(win.pos);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            ready_reg    <= 1'b0;
            lvl_reg      <= '0;
            row_reg      <= '0;
            wr_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            ready_reg    <= ready_next;
            lvl_reg      <= lvl_next;
            row_reg      <= row_next;
            wr_valid_reg <= wr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            cmd_reg <= cmd;
        end
        wr_addr_reg <= wr_addr_next;
        rsp_reg     <= rsp_next;
    end

    assign rsp = rsp_reg;

endmodule

>>> sv/sparse_table_range_argmax.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_table_range_argmax: range argmax over a sparse table
// Appends signed values, builds a table of window maxima per power-of-two
// level and answers position-of-maximum queries on [left, right].
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; exactly one result
// follows on rsp, marked by a single-cycle done pulse that the receiver must
// take as it comes. Clear and append pass through decode and the result
// register, a query through decode with the registered two-port table read,
// compare and the result register. Build runs level by level through the
// shared table memory, one pair read and one combined write per cycle within a
// level. busy drops in the cycle that done is shown, so a new command may
// start then.
// ----------------------------------------------------------------------------
module sparse_table_range_argmax
    import stra_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  cmd_t cmd,
    output logic busy,
    output logic done,
    output rsp_t rsp
);

    ctrl_cmd_t ctl;
    dp_stat_t  stat;

    stra_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    stra_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .ctl   (ctl),
        .stat  (stat),
        .rsp   (rsp)
    );

endmodule

>>> sv/stra_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stra_checker: port-level checks of the range argmax block
// Watches the command/result handshake and the result encoding.
// ----------------------------------------------------------------------------
module stra_checker
    import stra_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input rsp_t rsp
);

    // A result always comes with the block free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done shown while busy");

    // Every transfer in occupies the block on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command taken but block not busy");

    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a command");

    // Every command passes through decode and the result register, so results never come back to back
    a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results in consecutive cycles");

    a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.status != ST_OK)) |-> (rsp.max_position == '0))
        else $error("position nonzero on a failed item");

endmodule

bind sparse_table_range_argmax stra_checker u_stra_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sparse table range argmax block
// Drives clear, append, build and query commands in random bursts, predicts
// each response from a private copy of the element store and window table,
// and checks every done pulse in order against the predicted response.
// ----------------------------------------------------------------------------
module tb_top;
    import stra_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int QUIET_LIMIT  = 40000;
    localparam int RANDOM_ITEMS = 500;

    class range_argmax_board;
        logic signed [VALUE_WIDTH-1:0] elems   [MAX_ELEMENTS];
        logic signed [VALUE_WIDTH-1:0] win_max [LEVELS][MAX_ELEMENTS];
        logic [IDX_W-1:0]              win_pos [LEVELS][MAX_ELEMENTS];
        int unsigned                   n_elems;
        bit                            table_built;
        rsp_t                          expected_rsp [$];
        int unsigned                   mismatches;

        function new();
            n_elems     = 0;
            table_built = 1'b0;
            mismatches  = 0;
        endfunction

        function void build_windows();
            int unsigned half;
            for (int unsigned i = 0; i < n_elems; i++) begin
                win_max[0][i] = elems[i];
                win_pos[0][i] = IDX_W'(i);
            end
            for (int unsigned k = 1; k < LEVELS; k++) begin
                half = 1 << (k - 1);
                // Ties keep the left half.
                for (int unsigned i = 0; i + 2 * half <= n_elems; i++) begin
                    if (win_max[k-1][i] >= win_max[k-1][i+half]) begin
                        win_max[k][i] = win_max[k-1][i];
                        win_pos[k][i] = win_pos[k-1][i];
                    end
                    else begin
                        win_max[k][i] = win_max[k-1][i+half];
                        win_pos[k][i] = win_pos[k-1][i+half];
                    end
                end
            end
            table_built = 1'b1;
        endfunction

        function rsp_t predict(cmd_t c);
            rsp_t        r;
            int unsigned lo;
            int unsigned hi;
            int unsigned span;
            int unsigned k;
            int unsigned j;
            r.status       = ST_OK;
            r.max_position = '0;
            case (c.operation)
                OP_CLEAR: begin
                    n_elems     = 0;
                    table_built = 1'b0;
                end
                OP_APPEND: begin
                    if (n_elems >= MAX_ELEMENTS)
                        r.status = ST_FULL;
                    else begin
                        elems[n_elems] = c.value;
                        n_elems++;
                        table_built = 1'b0;
                    end
                end
                OP_BUILD: build_windows();
                OP_QUERY: begin
                    lo = c.left_index;
                    hi = c.right_index;
                    if (!table_built)
                        r.status = ST_NOT_BUILT;
                    else if (lo > hi || hi >= n_elems)
                        r.status = ST_BAD_RANGE;
                    else begin
                        span = hi - lo + 1;
                        k    = 0;
                        while ((span >> (k + 1)) != 0)
                            k++;
                        if (k >= LEVELS)
                            r.status = ST_BAD_RANGE;
                        else begin
                            // Two overlapping windows; the left one wins a tie.
                            j = hi + 1 - (1 << k);
                            r.max_position = (win_max[k][lo] >= win_max[k][j]) ?
                                             win_pos[k][lo] : win_pos[k][j];
                        end
                    end
                end
            endcase
            return r;
        endfunction

        function void note_command(cmd_t c);
            expected_rsp.push_back(predict(c));
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (expected_rsp.size() == 0) begin
                $display("%0t: unexpected response, expected none, got status %0d position %0d",
                         $time, got.status, got.max_position);
                mismatches++;
                return;
            end
            want = expected_rsp.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status mismatch, expected %0d, got %0d",
                         $time, want.status, got.status);
                mismatches++;
            end
            if (got.max_position !== want.max_position) begin
                $display("%0t: max_position mismatch, expected %0d, got %0d",
                         $time, want.max_position, got.max_position);
                mismatches++;
            end
        endfunction
    endclass

    logic              clk   = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    cmd_t              cmd   = '0;
    logic              busy;
    logic              done;
    rsp_t              rsp;
    range_argmax_board board;
    int unsigned       burst_left   = 0;
    int unsigned       items_sent   = 0;
    int unsigned       quiet_cycles = 0;

    sparse_table_range_argmax i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_response(rsp);
    end

    // End the run if neither a transfer nor a response happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic hold_off(input int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Hold start low until every predicted response has come back.
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (board.expected_rsp.size() != 0);
    endtask

    task automatic pace();
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
                hold_off($urandom_range(1, 15));
        end
        else
            burst_left--;
    endtask

    task automatic send(input op_t op, input logic [31:0] v,
                        input logic [9:0] l, input logic [9:0] r);
        cmd_t c;
        c.operation   = op;
        c.value       = v;
        c.left_index  = l;
        c.right_index = r;
        start <= 1'b1;
        cmd   <= c;
        do @(posedge clk); while (busy !== 1'b0);
        board.note_command(c);
        items_sent++;
        pace();
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2, 3:    return 32'(int'($urandom_range(0, 6)) - 3);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_query_valid();
        int unsigned lo;
        int unsigned hi;
        lo = $urandom_range(0, board.n_elems - 1);
        hi = $urandom_range(lo, board.n_elems - 1);
        send(OP_QUERY, $urandom, lo, hi);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 6))
            send(op_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
    endtask

    // Optionally clear, then fill, build, then mostly in-range queries with some broken ones.
    task automatic run_sequence();
        int unsigned n;
        int unsigned lo;
        int unsigned hi;
        if ($urandom_range(0, 4) != 0)
            send(OP_CLEAR, $urandom, $urandom, $urandom);
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(65, 300) : $urandom_range(1, 40);
        repeat (n)
            send(OP_APPEND, pick_value(), $urandom, $urandom);
        if ($urandom_range(0, 5) == 0)
            send(OP_QUERY, $urandom, $urandom, $urandom);
        send(OP_BUILD, $urandom, $urandom, $urandom);
        repeat ($urandom_range(4, 16)) begin
            case ($urandom_range(0, 9))
                0: send(OP_QUERY, $urandom, $urandom, $urandom);
                1: begin
                    hi = $urandom_range(0, 1022);
                    lo = $urandom_range(hi + 1, 1023);
                    send(OP_QUERY, $urandom, lo, hi);
                end
                2: begin
                    hi = board.n_elems + $urandom_range(0, 3);
                    if (hi > 1023)
                        hi = 1023;
                    lo = $urandom_range(0, hi);
                    send(OP_QUERY, $urandom, lo, hi);
                end
                default: begin
                    if (board.n_elems == 0)
                        send(OP_QUERY, $urandom, $urandom, $urandom);
                    else
                        send_query_valid();
                end
            endcase
        end
        // Stale table after a late append.
        if ($urandom_range(0, 4) == 0) begin
            send(OP_APPEND, pick_value(), $urandom, $urandom);
            send(OP_QUERY, $urandom, 0, 0);
        end
    endtask

    initial
    begin
        board = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, extremes, ties, bad ranges, stale table.
        send(OP_QUERY,  $urandom, 0, 0);
        send(OP_BUILD,  $urandom, $urandom, $urandom);
        send(OP_QUERY,  $urandom, 0, 0);
        send(OP_APPEND, 32'h8000_0000, $urandom, $urandom);
        send(OP_APPEND, 32'h7FFF_FFFF, $urandom, $urandom);
        send(OP_APPEND, 32'hFFFF_FFFF, $urandom, $urandom);
        send(OP_APPEND, 32'h7FFF_FFFF, $urandom, $urandom);
        send(OP_APPEND, 32'h0000_0000, $urandom, $urandom);
        send(OP_QUERY,  $urandom, 0, 4);
        send(OP_BUILD,  $urandom, $urandom, $urandom);
        send(OP_QUERY,  $urandom, 0, 4);
        send(OP_QUERY,  $urandom, 2, 4);
        send(OP_QUERY,  $urandom, 0, 0);
        send(OP_QUERY,  $urandom, 4, 4);
        send(OP_QUERY,  $urandom, 2, 3);
        send(OP_QUERY,  $urandom, 3, 1);
        send(OP_QUERY,  $urandom, 0, 5);
        send(OP_QUERY,  $urandom, 1023, 1023);
        send(OP_APPEND, 32'h5A5A_A5A5, $urandom, $urandom);
        send(OP_QUERY,  $urandom, 0, 5);
        send(OP_CLEAR,  $urandom, $urandom, $urandom);
        send(OP_QUERY,  $urandom, 0, 0);
        send(OP_BUILD,  $urandom, $urandom, $urandom);
        send(OP_QUERY,  $urandom, 0, 0);
        drain();

        // Fill the store completely, overflow it once, query the full span.
        send(OP_CLEAR, $urandom, $urandom, $urandom);
        repeat (MAX_ELEMENTS)
            send(OP_APPEND, pick_value(), $urandom, $urandom);
        send(OP_APPEND, pick_value(), $urandom, $urandom);
        send(OP_BUILD,  $urandom, $urandom, $urandom);
        send(OP_QUERY,  $urandom, 0, 1023);
        send(OP_QUERY,  $urandom, 1023, 1023);
        send(OP_QUERY,  $urandom, 0, 0);
        send(OP_QUERY,  $urandom, 512, 1023);
        repeat (20)
            send_query_valid();

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0)
                send_noise();
            else
                run_sequence();
            if ($urandom_range(0, 7) == 0)
                drain();
        end

        drain();
        repeat (8) @(posedge clk);
        if (board.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
sv/stra_pkg.sv
sv/stra_ctrl.sv
sv/stra_dp.sv
sv/sparse_table_range_argmax.sv
sv/stra_checker.sv
verif/tb_top.sv
